// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the hash set sequencer. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== src/hslp_pkg.sv =====
// ----------------------------------------------------------------------------
// hslp_pkg
// Shared constants, codes and controller/datapath interface types of the
// linear-probing hash set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hslp_pkg;

    localparam int KEY_W          = 64;
    localparam int SLOT_W         = 12;
    localparam int STATUS_W       = 2;
    localparam int LIMIT_W        = 7;
    localparam int TABLE_BITS_DEF = 12;

    localparam logic [LIMIT_W-1:0] PROBE_MAX   = 7'd64;
    localparam logic [LIMIT_W-1:0] PROBE_MIN   = 7'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Operation codes of an input beat.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

    // Mixer constants of the splitmix64 finalizer.
    localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    // Partial product selectors of the 64-bit low-half multiply.
    localparam logic [1:0] PART_LL = 2'd0;  // a_lo * c_lo
    localparam logic [1:0] PART_LH = 2'd1;  // a_lo * c_hi
    localparam logic [1:0] PART_HL = 2'd2;  // a_hi * c_lo

    typedef struct packed {
        logic                load;      // capture key, first xor-shift
        logic                mul_en;    // one partial product step
        logic [1:0]          mul_part;
        logic                round;     // 0 first mix round, 1 second
        logic                xs_en;     // xor-shift between/after rounds
        logic                clr_init;  // restart the sweep index
        logic                clr_wr;    // drop one used mark, advance
        logic                ins_wr;    // store key, set used mark
        logic                advance;   // step to the next slot
        logic                res_en;    // issue a result beat
        logic [STATUS_W-1:0] res_code;
    } t_cmd;

    typedef struct packed {
        logic free;      // probed slot is unused
        logic match;     // probed slot holds the key
        logic last;      // probed slot is the last one allowed
        logic idx_last;  // sweep index at the top slot
    } t_stat;

endpackage

`default_nettype wire

// ===== src/hash_set_insert_linear_probe_core.sv =====
// ----------------------------------------------------------------------------
// hash_set_insert_linear_probe_core
// Open-addressing hash set of 64-bit keys with linear probing and a
// splitmix64 key mixer.
// ----------------------------------------------------------------------------
// Usage:
// An input beat (i_operation, i_key) is taken at a rising edge with start
// high and busy low. Insert hashes the key, probes slots home, home+1, ...
// (wrapping) up to the configured limit and stores the key in the first
// free slot. Clear drops every used mark and leaves the keys in place.
// Every beat gives exactly one result beat on o_status/o_slot, marked by
// o_strobe for one cycle; the receiver cannot stall, so nothing waits.
// An insert first mixes the key (two rounds of three 32x32 partial
// products on the single shared multiplier, plus one xor-shift step each),
// then examines each slot with a memory read, then a check, with the
// result on the ports in the cycle after the last check. A clear walks
// the used-mark memory one entry per cycle. busy falls in the cycle the
// result is shown, so the next beat can be taken right away. After reset
// the same sweep of all 2^TABLE_BITS entries (4096 by default) clears the
// used marks while busy stays high; it gives no result. i_cfg_we writes
// the probe limit (reset 64); the user must do so only while the block is
// idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_set_insert_linear_probe_core #(
    parameter int TABLE_BITS = hslp_pkg::TABLE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_operation,
    input  wire  [hslp_pkg::KEY_W-1:0]         i_key,
    input  wire                                i_cfg_we,
    input  wire  [hslp_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    output logic                               o_strobe,
    output logic [hslp_pkg::STATUS_W-1:0]      o_status,
    output logic [hslp_pkg::SLOT_W-1:0]        o_slot
);

    hslp_pkg::t_cmd  w_cmd;
    hslp_pkg::t_stat w_stat;

    // The sequencer decides; the datapath holds keys, table and results.
    hslp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_operation),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    hslp_dp #(
        .TABLE_BITS (TABLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_key),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

endmodule

`default_nettype wire

// ===== src/hslp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hslp_ctrl
// Sequencer of the hash set engine: reset sweep, clear sweep, the eight-step
// key mixer and the probe loop.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hslp_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_op,
    input  hslp_pkg::t_stat     i_stat,
    output hslp_pkg::t_cmd      o_cmd,
    output logic                o_busy
);

    localparam logic [2:0] S_RCLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_XS   = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_part, n_part;
    logic       r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RCLR;
            r_part  <= hslp_pkg::PART_LL;
            r_round <= 1'b0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_part         = r_part;
        n_round        = r_round;
        o_cmd          = '0;
        o_cmd.mul_part = r_part;
        o_cmd.round    = r_round;
        case (r_state)
            S_RCLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == hslp_pkg::OP_CLEAR) begin
                        o_cmd.clr_init = 1'b1;
                        n_state        = S_CLR;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_part     = hslp_pkg::PART_LL;
                        n_round    = 1'b0;
                        n_state    = S_MUL;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_code = hslp_pkg::ST_CLEARED;
                    n_state        = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_part == hslp_pkg::PART_HL) begin
                    n_part  = hslp_pkg::PART_LL;
                    n_state = S_XS;
                end else begin
                    n_part = r_part + 2'd1;
                end
            end
            S_XS: begin
                o_cmd.xs_en = 1'b1;
                if (!r_round) begin
                    n_round = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.free) begin
                    o_cmd.ins_wr   = 1'b1;
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_code = hslp_pkg::ST_INSERTED;
                    n_state        = S_IDLE;
                end else if (i_stat.match) begin
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_code = hslp_pkg::ST_PRESENT;
                    n_state        = S_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_code = hslp_pkg::ST_OVERFLOW;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // Every result ends the work on its item.
    `ASSERT_PROP(a_res_then_idle, i_clk, i_rst_n, o_cmd.res_en |=> (r_state == S_IDLE))
    // A slot is only checked after its read cycle.
    `ASSERT_PROP(a_chk_after_rd, i_clk, i_rst_n, (r_state == S_CHK) |-> ($past(r_state) == S_RD))
    // The multiply uses only three partial products.
    `ASSERT_NEVER(a_part_range, i_clk, i_rst_n, (r_state == S_MUL) && (r_part == 2'd3))
    // A store into the table happens only when a result is issued.
    `ASSERT_PROP(a_ins_has_res, i_clk, i_rst_n, o_cmd.ins_wr |-> o_cmd.res_en)

endmodule

`default_nettype wire

// ===== src/hslp_dp.sv =====
// ----------------------------------------------------------------------------
// hslp_dp
// Datapath of the hash set engine: key mixer with a shared 32x32 multiplier,
// key and used-mark memories, probe index and count, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_dp #(
    parameter int TABLE_BITS = hslp_pkg::TABLE_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  [hslp_pkg::KEY_W-1:0]            i_key,
    input  wire                                   i_cfg_we,
    input  wire  [hslp_pkg::LIMIT_W-1:0]          i_cfg_wdata,
    input  hslp_pkg::t_cmd                        i_cmd,
    output hslp_pkg::t_stat                       o_stat,
    output logic                                  o_strobe,
    output logic [hslp_pkg::STATUS_W-1:0]         o_status,
    output logic [hslp_pkg::SLOT_W-1:0]           o_slot
);

    localparam int DEPTH = 1 << TABLE_BITS;
    localparam int KW    = hslp_pkg::KEY_W;
    localparam int HW    = KW / 2;

    logic [KW-1:0]                   key_mem  [DEPTH];
    logic                            used_mem [DEPTH];

    logic [KW-1:0]                   r_key;
    logic [KW-1:0]                   r_x;
    logic [KW-1:0]                   r_acc;
    logic [TABLE_BITS-1:0]           r_idx;
    logic [hslp_pkg::LIMIT_W-1:0]    r_cnt;
    logic [hslp_pkg::LIMIT_W-1:0]    r_limit;
    logic [KW-1:0]                   r_rd_key;
    logic                            r_rd_used;
    logic                            r_strobe;
    logic [hslp_pkg::STATUS_W-1:0]   r_status;
    logic [hslp_pkg::SLOT_W-1:0]     r_slot;

    logic [KW-1:0]                   w_const;
    logic [HW-1:0]                   w_mul_a;
    logic [HW-1:0]                   w_mul_b;
    logic [KW-1:0]                   w_prod;
    logic [KW-1:0]                   w_mix;
    logic [hslp_pkg::LIMIT_W-1:0]    w_lim;
    logic [hslp_pkg::LIMIT_W-1:0]    w_cnt_inc;
    logic                            w_used_we;

    // One 32x32 partial product per step; only the low 64 bits are kept.
    assign w_const = i_cmd.round ? hslp_pkg::MIX_C2 : hslp_pkg::MIX_C1;
    assign w_mul_a = (i_cmd.mul_part == hslp_pkg::PART_HL) ? r_x[KW-1:HW] : r_x[HW-1:0];
    assign w_mul_b = (i_cmd.mul_part == hslp_pkg::PART_LH) ? w_const[KW-1:HW]
                                                           : w_const[HW-1:0];
    assign w_prod  = KW'(w_mul_a) * KW'(w_mul_b);
    assign w_mix   = r_acc ^ (r_acc >> hslp_pkg::MIX_SH3);

    // The limit register saturates into the legal range when used.
    always_comb begin
        if (r_limit < hslp_pkg::PROBE_MIN) begin
            w_lim = hslp_pkg::PROBE_MIN;
        end else if (r_limit > hslp_pkg::PROBE_MAX) begin
            w_lim = hslp_pkg::PROBE_MAX;
        end else begin
            w_lim = r_limit;
        end
    end

    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_used_we = i_cmd.clr_wr | i_cmd.ins_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= hslp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.clr_init) begin
                r_idx <= '0;
            end else if (i_cmd.clr_wr) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.xs_en && i_cmd.round) begin
                r_idx <= w_mix[TABLE_BITS-1:0];
                r_cnt <= '0;
            end else if (i_cmd.advance) begin
                r_idx <= r_idx + 1'b1;
                r_cnt <= w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_x   <= i_key ^ (i_key >> hslp_pkg::MIX_SH1);
        end else if (i_cmd.xs_en && !i_cmd.round) begin
            r_x   <= r_acc ^ (r_acc >> hslp_pkg::MIX_SH2);
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_part == hslp_pkg::PART_LL) begin
                r_acc <= w_prod;
            end else begin
                r_acc[KW-1:HW] <= r_acc[KW-1:HW] + w_prod[HW-1:0];
            end
        end
    end

    // Table memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_used_we) begin
            used_mem[r_idx] <= i_cmd.ins_wr;
        end
        if (i_cmd.ins_wr) begin
            key_mem[r_idx] <= r_key;
        end
        r_rd_used <= used_mem[r_idx];
        r_rd_key  <= key_mem[r_idx];
    end

    assign o_stat.free     = !r_rd_used;
    assign o_stat.match    = (r_rd_key == r_key);
    assign o_stat.last     = (w_cnt_inc >= w_lim);
    assign o_stat.idx_last = &r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.res_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_en) begin
            r_status <= i_cmd.res_code;
            if (i_cmd.res_code == hslp_pkg::ST_INSERTED ||
                i_cmd.res_code == hslp_pkg::ST_PRESENT) begin
                r_slot <= hslp_pkg::SLOT_W'(r_idx);
            end else begin
                r_slot <= '0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

`default_nettype wire
